/* rtl/ebapw_pkg.sv */
// ----------------------------------------------------------------------------
// ebapw_pkg
// Shared types and constants of the EEPROM block allocator and page writer.
// ----------------------------------------------------------------------------
package ebapw_pkg;

   localparam int PAGE_LOG2  = 7;
   localparam int PAGE_BYTES = 1 << PAGE_LOG2;

   localparam int SIZE_W   = 12;
   localparam int HANDLE_W = 5;
   localparam int ADDR_W   = 14;
   localparam int ALIGN_W  = SIZE_W + 1;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [1:0] {
      REQ_REGISTER  = 2'd0,
      REQ_WRITE     = 2'd1,
      REQ_PAGE_DONE = 2'd2,
      REQ_READ      = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic load;
      logic walk_step;
      logic issue;
   } ctl_cmd_type;

   typedef struct packed {
      logic walk_needed;
      logic walk_end;
      logic out_free;
   } dp_sts_type;

   function automatic logic [ALIGN_W-1:0] align4(input logic [SIZE_W-1:0] v);
      logic [ALIGN_W-1:0] s;
      s = {1'b0, v} + ALIGN_W'(3);
      return {s[ALIGN_W-1:2], 2'b00};
   endfunction

endpackage

/* rtl/ebapw_ram.sv */
// ----------------------------------------------------------------------------
// ebapw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ebapw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/ebapw_ctrl.sv */
// ----------------------------------------------------------------------------
// ebapw_ctrl
// Request sequencer: accepts one request, runs the slot walk, issues result.
// ----------------------------------------------------------------------------
module ebapw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ebapw_pkg::dp_sts_type sts,
   output ebapw_pkg::ctl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.walk_step = 1'b0;
      cmd.issue     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.walk_needed ? S_WALK : S_DONE;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.issue = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

/* rtl/ebapw_dp.sv */
// ----------------------------------------------------------------------------
// ebapw_dp
// Slot table, allocation walk, page chunking and result register.
// ----------------------------------------------------------------------------
module ebapw_dp #(
   parameter int SLOT_COUNT      = 16,
   parameter int CAPACITY_BYTES  = 16256,
   parameter int MAX_BLOCK_BYTES = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ebapw_pkg::ctl_cmd_type              cmd,
   output ebapw_pkg::dp_sts_type               sts,
   input  logic [ebapw_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ebapw_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int OFS_W = $clog2(CAPACITY_BYTES + 1);
   localparam int TOT_W = $clog2(CAPACITY_BYTES + 4096 + 1);
   localparam int SZ_W  = ebapw_pkg::SIZE_W;
   localparam int AL_W  = ebapw_pkg::ALIGN_W;
   localparam int ENT_W = OFS_W + SZ_W;

   // request capture
   logic [1:0]                       req_kind_ff;
   logic [SZ_W-1:0]                  req_size_ff;
   logic [ebapw_pkg::HANDLE_W-1:0]   req_handle_ff;

   // slot table
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic                  ram_we, ram_re;
   logic [IDX_W-1:0]      ram_waddr, ram_raddr;
   logic [ENT_W-1:0]      ram_wdata, ram_rdata;
   logic [OFS_W-1:0]      ent_offset;
   logic [SZ_W-1:0]       ent_size;

   // walk
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic             taken_ff, taken_in;
   logic [IDX_W-1:0] taken_idx_ff, taken_idx_in;
   logic             fail_ff, fail_in;
   logic             slot_used, take_now, over;
   logic [AL_W-1:0]  walk_add;

   // write sequencer
   logic             busy_ff, busy_in;
   logic [AL_W-1:0]  rem_ff, rem_in;
   logic [TOT_W-1:0] next_addr_ff, next_addr_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ebapw_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // result fields
   logic                            r_ok, r_prog;
   logic [ebapw_pkg::HANDLE_W-1:0]  r_hout;
   logic [ebapw_pkg::ADDR_W-1:0]    r_addr;
   logic [SZ_W-1:0]                 r_len;

   logic [IDX_W-1:0] in_hidx, hidx;
   logic             hvalid;
   logic [AL_W-1:0]  a4, po, tr_w, tr_p;
   logic [AL_W:0]    po_sum;

   assign ent_offset = ram_rdata[ENT_W-1:SZ_W];
   assign ent_size   = ram_rdata[SZ_W-1:0];

   assign in_hidx = IDX_W'(req_tdata[16:12] - 5'd1);
   assign hidx    = IDX_W'(req_handle_ff - 5'd1);
   assign hvalid  = (req_handle_ff != '0) && (32'(req_handle_ff) <= SLOT_COUNT)
                    && used_ff[hidx];

   assign sts.walk_needed = (req_tuser == ebapw_pkg::REQ_REGISTER)
                            && (32'(req_tdata[11:0]) <= MAX_BLOCK_BYTES);
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   // walk step over one slot
   assign slot_used = used_ff[walk_idx_ff];
   assign take_now  = !taken_ff && !slot_used;
   assign walk_add  = take_now  ? ebapw_pkg::align4(req_size_ff) :
                      slot_used ? ebapw_pkg::align4(ent_size) : '0;
   assign total_in  = total_ff + TOT_W'(walk_add);
   assign over      = total_in > TOT_W'(CAPACITY_BYTES);
   assign sts.walk_end = over || (walk_idx_ff == IDX_W'(SLOT_COUNT - 1));

   assign ram_we    = cmd.walk_step && take_now;
   assign ram_waddr = walk_idx_ff;
   assign ram_wdata = {OFS_W'(total_ff), req_size_ff};
   assign ram_re    = cmd.load || cmd.walk_step;
   assign ram_raddr = cmd.load ? (sts.walk_needed ? '0 : in_hidx) : IDX_W'(walk_idx_ff + 1'b1);

   ebapw_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // chunk sizes
   assign a4     = ebapw_pkg::align4(ent_size);
   assign po     = AL_W'(ent_offset[ebapw_pkg::PAGE_LOG2-1:0]);
   assign po_sum = {1'b0, po} + {1'b0, a4};
   assign tr_w   = (po_sum > (AL_W + 1)'(ebapw_pkg::PAGE_BYTES)) ?
                   AL_W'(ebapw_pkg::PAGE_BYTES) - po : a4;
   assign tr_p   = (rem_ff > AL_W'(ebapw_pkg::PAGE_BYTES)) ?
                   AL_W'(ebapw_pkg::PAGE_BYTES) : rem_ff;

   always_comb begin
      walk_idx_in  = walk_idx_ff;
      taken_in     = taken_ff;
      taken_idx_in = taken_idx_ff;
      fail_in      = fail_ff;
      used_in      = used_ff;
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      next_addr_in = next_addr_ff;
      r_ok         = 1'b0;
      r_prog       = 1'b0;
      r_hout       = '0;
      r_addr       = '0;
      r_len        = '0;

      if (cmd.load) begin
         walk_idx_in = '0;
         taken_in    = 1'b0;
         fail_in     = 1'b0;
      end

      if (cmd.walk_step) begin
         walk_idx_in = IDX_W'(walk_idx_ff + 1'b1);
         if (take_now) begin
            taken_in     = 1'b1;
            taken_idx_in = walk_idx_ff;
         end
         if (over) begin
            fail_in = 1'b1;
         end
      end

      unique case (ebapw_pkg::req_kind_type'(req_kind_ff))
         ebapw_pkg::REQ_REGISTER: begin
            if (taken_ff && !fail_ff) begin
               r_ok   = 1'b1;
               r_hout = ebapw_pkg::HANDLE_W'(32'(taken_idx_ff) + 1);
               if (cmd.issue) begin
                  used_in[taken_idx_ff] = 1'b1;
               end
            end
         end
         ebapw_pkg::REQ_WRITE: begin
            if (hvalid) begin
               rem_in = a4;
               if (a4 == '0) begin
                  r_ok = 1'b1;
               end else if (!busy_ff) begin
                  next_addr_in = TOT_W'(ent_offset) + TOT_W'(tr_w);
                  rem_in       = a4 - tr_w;
                  busy_in      = 1'b1;
                  r_ok         = 1'b1;
                  r_prog       = 1'b1;
                  r_addr       = ebapw_pkg::ADDR_W'(ent_offset);
                  r_len        = SZ_W'(tr_w);
               end
            end
         end
         ebapw_pkg::REQ_PAGE_DONE: begin
            if (busy_ff) begin
               busy_in = 1'b0;
               if (rem_ff != '0) begin
                  r_addr       = ebapw_pkg::ADDR_W'(next_addr_ff);
                  r_len        = SZ_W'(tr_p);
                  next_addr_in = next_addr_ff + TOT_W'(tr_p);
                  rem_in       = rem_ff - tr_p;
                  busy_in      = 1'b1;
                  r_ok         = 1'b1;
                  r_prog       = 1'b1;
               end
            end
         end
         ebapw_pkg::REQ_READ: begin
            if (hvalid && !busy_ff) begin
               r_ok   = 1'b1;
               r_addr = ebapw_pkg::ADDR_W'(ent_offset);
               r_len  = ent_size;
            end
         end
         default: r_ok = 1'b0;
      endcase

      rsp_data_in = {6'b0, busy_in, r_prog, r_len, r_addr, r_hout, r_ok};

      rsp_valid_in = rsp_valid_ff;
      if (cmd.issue) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         busy_ff      <= 1'b0;
         rem_ff       <= '0;
         next_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         walk_idx_ff  <= '0;
         total_ff     <= '0;
         taken_ff     <= 1'b0;
         fail_ff      <= 1'b0;
      end else begin
         walk_idx_ff <= walk_idx_in;
         taken_ff    <= taken_in;
         fail_ff     <= fail_in;
         if (cmd.load) begin
            total_ff <= '0;
         end else if (cmd.walk_step) begin
            total_ff <= total_in;
         end
         if (cmd.issue) begin
            used_ff      <= used_in;
            busy_ff      <= busy_in;
            rem_ff       <= rem_in;
            next_addr_ff <= next_addr_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taken_idx_ff <= taken_idx_in;
      if (cmd.load) begin
         req_kind_ff   <= req_tuser;
         req_size_ff   <= req_tdata[11:0];
         req_handle_ff <= req_tdata[16:12];
      end
      if (cmd.issue) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/eeprom_block_allocator_page_writer.sv */
// ----------------------------------------------------------------------------
// eeprom_block_allocator_page_writer
// Block slot allocator for an EEPROM with a page program sequencer.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: block_size, block_handle
//                                        tuser: req_type
//   rsp      out  rsp_tvalid/rsp_tready  tdata: ok, handle_out, address,
//                                        length, program_start, busy_res
//
// register requests of up to MAX_BLOCK_BYTES walk the slot table one slot
// per cycle through the slot ram; the walk ends early when capacity runs out
// other requests take one slot ram read, then the result
// one request at a time; a new request is taken while the result waits
// reset is synchronous; it frees all slots and ends any write in progress
// a stalled result holds the sequencer until the result transfer completes
// ----------------------------------------------------------------------------
module eeprom_block_allocator_page_writer #(
   parameter int SLOT_COUNT      = 16,
   parameter int CAPACITY_BYTES  = 16256,
   parameter int MAX_BLOCK_BYTES = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [11:0] block_size, [16:12] block_handle, [23:17] zero
   input  logic [ebapw_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] req_type
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] ok, [5:1] handle_out, [19:6] address, [31:20] length,
   // [32] program_start, [33] busy_res, [39:34] zero
   output logic [ebapw_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   ebapw_pkg::ctl_cmd_type cmd;
   ebapw_pkg::dp_sts_type  sts;

   ebapw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ebapw_dp #(
      .SLOT_COUNT      (SLOT_COUNT),
      .CAPACITY_BYTES  (CAPACITY_BYTES),
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* test/eeprom_block_allocator_page_writer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eeprom_block_allocator_page_writer_test
// Self-checking bench for the block allocator and page writer. Requests are
// streamed in under random backpressure. A slot table tracker predicts every
// response: allocation, page-split program commands and block info reads.
// ----------------------------------------------------------------------------
module eeprom_block_allocator_page_writer_test;

   localparam int SLOTS       = 16;
   localparam int CAPACITY    = 16256;
   localparam int MAX_BLOCK   = 2048;
   localparam int ITEM_TARGET = 1650;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic        ok;
      logic [4:0]  handle;
      logic [13:0] address;
      logic [11:0] length;
      logic        prog;
      logic        busy;
   } rsp_fields_type;

   class block_table_scoreboard;
      bit             used[SLOTS];
      int             offsets[SLOTS];
      int             sizes[SLOTS];
      bit             busy;
      int             remaining;
      int             next_addr;
      rsp_fields_type pending_responses[$];
      int             errors;

      function int round_up4(int v);
         return (v + 3) & ~3;
      endfunction

      function int pending();
         return pending_responses.size();
      endfunction

      function void note_request(ebapw_pkg::req_kind_type kind, int size, int handle);
         rsp_fields_type r;
         int total, taken, chunk, idx, pofs, i;
         bit valid;
         r = '{ok: 0, handle: 0, address: 0, length: 0, prog: 0, busy: 0};
         valid = handle >= 1 && handle <= SLOTS && used[handle - 1];
         idx = valid ? handle - 1 : 0;
         case (kind)
            ebapw_pkg::REQ_REGISTER: begin
               if (size <= MAX_BLOCK) begin
                  total = 0;
                  taken = -1;
                  for (i = 0; i < SLOTS; i++) begin
                     if (taken < 0 && !used[i]) begin
                        used[i] = 1;
                        sizes[i] = size;
                        offsets[i] = total;
                        taken = i;
                     end
                     total += round_up4(sizes[i]);
                     if (total > CAPACITY) begin
                        // capacity exceeded, undo the new slot
                        if (taken >= 0) begin
                           used[taken] = 0;
                           offsets[taken] = 0;
                           sizes[taken] = 0;
                        end
                        taken = -2;
                        break;
                     end
                  end
                  if (taken >= 0) begin
                     r.ok = 1;
                     r.handle = 5'(taken + 1);
                  end
               end
            end
            ebapw_pkg::REQ_WRITE: begin
               if (valid) begin
                  remaining = round_up4(sizes[idx]);
                  if (remaining == 0) begin
                     r.ok = 1;
                  end else if (!busy) begin
                     pofs = offsets[idx] % ebapw_pkg::PAGE_BYTES;
                     chunk = remaining;
                     if (pofs + chunk > ebapw_pkg::PAGE_BYTES) begin
                        chunk = ebapw_pkg::PAGE_BYTES - pofs;
                     end
                     next_addr = offsets[idx] + chunk;
                     remaining -= chunk;
                     busy = 1;
                     r.ok = 1;
                     r.prog = 1;
                     r.address = 14'(offsets[idx]);
                     r.length = 12'(chunk);
                  end
               end
            end
            ebapw_pkg::REQ_PAGE_DONE: begin
               if (busy) begin
                  busy = 0;
                  if (remaining != 0) begin
                     chunk = remaining > ebapw_pkg::PAGE_BYTES ? ebapw_pkg::PAGE_BYTES
                                                               : remaining;
                     r.address = 14'(next_addr);
                     r.length = 12'(chunk);
                     next_addr += chunk;
                     remaining -= chunk;
                     busy = 1;
                     r.ok = 1;
                     r.prog = 1;
                  end
               end
            end
            default: begin
               if (valid && !busy) begin
                  r.ok = 1;
                  r.address = 14'(offsets[idx]);
                  r.length = 12'(sizes[idx]);
               end
            end
         endcase
         r.busy = busy;
         pending_responses.push_back(r);
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [ebapw_pkg::RSP_DATA_W-1:0] d);
         rsp_fields_type e;
         if (pending_responses.size() == 0) begin
            $error("response transfer with no request outstanding: %h", d);
            errors++;
            return;
         end
         e = pending_responses.pop_front();
         compare("ok", 16'(e.ok), 16'(d[0]));
         compare("handle_out", 16'(e.handle), 16'(d[5:1]));
         compare("address", 16'(e.address), 16'(d[19:6]));
         compare("length", 16'(e.length), 16'(d[31:20]));
         compare("program_start", 16'(e.prog), 16'(d[32]));
         compare("busy_res", 16'(e.busy), 16'(d[33]));
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ebapw_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]                       req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ebapw_pkg::RSP_DATA_W-1:0] rsp_tdata;

   block_table_scoreboard table_sb = new();
   bit                    calm = 1'b0;
   int                    sent = 0;
   int                    idle_cycles = 0;

   eeprom_block_allocator_page_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 14);
   end

   // transfers are sampled mid-cycle, where inputs and outputs are stable
   always begin : response_monitor
      logic [ebapw_pkg::RSP_DATA_W-1:0] captured;
      @(negedge clock);
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         captured = rsp_tdata;
         @(posedge clock);
         table_sb.check_response(captured);
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("** eeprom_block_allocator_page_writer: FAILED **");
               $finish;
            end
         end
      end
   end

   task automatic send_item(input ebapw_pkg::req_kind_type kind, input logic [11:0] size,
                            input logic [4:0] handle);
      logic fire;
      while (!calm && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= ebapw_pkg::REQ_DATA_W'({handle, size});
      fire = 1'b0;
      while (!fire) begin
         @(negedge clock);
         fire = (req_tready === 1'b1);
         @(posedge clock);
      end
      table_sb.note_request(kind, size, handle);
      sent++;
   endtask

   task automatic drain_responses();
      while (table_sb.pending() != 0) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic random_item();
      send_item(ebapw_pkg::req_kind_type'($urandom_range(0, 3)),
                12'($urandom_range(0, 4095)), 5'($urandom_range(0, 31)));
   endtask

   function automatic logic [4:0] pick_handle();
      int h;
      if ($urandom_range(0, 99) < 85) begin
         do h = $urandom_range(1, SLOTS); while (!table_sb.used[h - 1]);
      end else begin
         h = $urandom_range(0, 31);
      end
      return 5'(h);
   endfunction

   initial begin : stimulus
      int r, k;
      logic [11:0] size;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: idle, invalid handles, oversize, alignment, page split
      send_item(ebapw_pkg::REQ_PAGE_DONE, 12'd0, 5'd0);
      send_item(ebapw_pkg::REQ_READ, 12'd0, 5'd0);
      send_item(ebapw_pkg::REQ_WRITE, 12'd0, 5'd1);
      send_item(ebapw_pkg::REQ_REGISTER, 12'd4095, 5'd0);
      send_item(ebapw_pkg::REQ_REGISTER, 12'd2049, 5'd0);
      send_item(ebapw_pkg::REQ_REGISTER, 12'd0, 5'd31);
      send_item(ebapw_pkg::REQ_REGISTER, 12'd2048, 5'd0);
      send_item(ebapw_pkg::REQ_REGISTER, 12'd1, 5'd0);
      send_item(ebapw_pkg::REQ_REGISTER, 12'd130, 5'd0);
      send_item(ebapw_pkg::REQ_WRITE, 12'd0, 5'd1);
      send_item(ebapw_pkg::REQ_READ, 12'hfff, 5'd4);
      send_item(ebapw_pkg::REQ_WRITE, 12'd0, 5'd4);
      send_item(ebapw_pkg::REQ_READ, 12'd0, 5'd2);
      send_item(ebapw_pkg::REQ_WRITE, 12'd0, 5'd3);
      send_item(ebapw_pkg::REQ_PAGE_DONE, 12'd0, 5'd0);
      send_item(ebapw_pkg::REQ_PAGE_DONE, 12'd0, 5'd0);
      send_item(ebapw_pkg::REQ_WRITE, 12'd0, 5'd31);
      send_item(ebapw_pkg::REQ_READ, 12'd0, 5'd17);
      for (k = 0; k < 7; k++) send_item(ebapw_pkg::REQ_REGISTER, 12'd2048, 5'd0);
      send_item(ebapw_pkg::REQ_WRITE, 12'd0, 5'd2);
      drain_responses();

      // random: mostly complete page write sequences with noise mixed in
      while (sent < ITEM_TARGET) begin
         calm = sent >= 700 && sent < 1000;
         if (sent % 400 < 3) drain_responses();
         r = $urandom_range(0, 99);
         if (r < 45) begin
            send_item(ebapw_pkg::REQ_WRITE, 12'($urandom), pick_handle());
            while (table_sb.busy) begin
               if ($urandom_range(0, 99) < 12) random_item();
               else send_item(ebapw_pkg::REQ_PAGE_DONE, 12'($urandom), 5'($urandom));
            end
         end else if (r < 60) begin
            k = $urandom_range(0, 99);
            if (k < 40) size = 12'($urandom_range(0, 64));
            else if (k < 75) size = 12'($urandom_range(0, MAX_BLOCK));
            else size = 12'($urandom_range(0, 4095));
            send_item(ebapw_pkg::REQ_REGISTER, size, 5'($urandom));
         end else if (r < 75) begin
            send_item(ebapw_pkg::REQ_READ, 12'($urandom), pick_handle());
         end else begin
            random_item();
         end
      end
      calm = 1'b0;
      drain_responses();
      repeat (40) @(posedge clock);

      if (table_sb.pending() != 0) begin
         $error("%0d expected responses never arrived", table_sb.pending());
      end
      if (table_sb.errors == 0 && table_sb.pending() == 0) begin
         $display("** eeprom_block_allocator_page_writer: PASSED **");
      end else begin
         $display("** eeprom_block_allocator_page_writer: FAILED **");
      end
      $finish;
   end

endmodule
